>>> design/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, tables and byte-level helpers for the aes-128 core
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ENC_KEY_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ENC_KEY_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DEC_KEY_HIGH = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DEC_KEY_LOW  = 2'd3;

  localparam logic [7:0] RconEncStart = 8'h01;
  localparam logic [7:0] RconDecStart = 8'h36;
  localparam logic [7:0] RconDecWrap  = 8'h80;

  // operation carried in tuser
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  // byte 0 in bits 127:120
  typedef logic [127:0] blk_t;

  // one pipeline slot: direction, state, running key, round constant
  typedef struct packed {
    logic       dec;
    blk_t       st;
    blk_t       key;
    logic [7:0] rc;
  } slot_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
    return b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rc_next(input logic dec, input logic [7:0] rc);
    if (dec) return rc[0] ? RconDecWrap : {1'b0, rc[7:1]};
    return xt(rc);
  endfunction

  // forward key schedule step
  function automatic blk_t key_fwd(input blk_t k, input logic [7:0] rc);
    logic [7:0] b [16];
    blk_t r;
    for (int i = 0; i < 16; i++) b[i] = get_byte(k, i);
    b[0] = b[0] ^ SBOX[b[13]] ^ rc;
    b[1] = b[1] ^ SBOX[b[14]];
    b[2] = b[2] ^ SBOX[b[15]];
    b[3] = b[3] ^ SBOX[b[12]];
    for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i-4];
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
    return r;
  endfunction

  // backward key schedule step
  function automatic blk_t key_bwd(input blk_t k, input logic [7:0] rc);
    logic [7:0] b [16];
    logic [7:0] o [16];
    blk_t r;
    for (int i = 0; i < 16; i++) b[i] = get_byte(k, i);
    for (int i = 4; i < 16; i++) o[i] = b[i] ^ b[i-4];
    o[0] = b[0] ^ SBOX[o[13]] ^ rc;
    o[1] = b[1] ^ SBOX[o[14]];
    o[2] = b[2] ^ SBOX[o[15]];
    o[3] = b[3] ^ SBOX[o[12]];
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = o[i];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// one registered round, forward or inverse, with its key step
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round
  import aes_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire slot_t in_slot,
  input  wire logic  first,
  input  wire logic  last,
  output logic       out_valid,
  output slot_t      out_slot
);

  slot_t nx;

  // round datapath
  always_comb begin
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al, u, v;
    blk_t k;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; al = '0; u = '0; v = '0;
    nx = in_slot;
    for (int i = 0; i < 16; i++) s[i] = get_byte(in_slot.st, i);
    if (!in_slot.dec) begin
      for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r+4*c] = s[r + 4*((c+r) & 3)];
      if (!last) begin
        for (int c = 0; c < 16; c += 4) begin
          a0 = t[c]; a1 = t[c+1]; a2 = t[c+2]; a3 = t[c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[c]   = a0 ^ al ^ xt(a0 ^ a1);
          t[c+1] = a1 ^ al ^ xt(a1 ^ a2);
          t[c+2] = a2 ^ al ^ xt(a2 ^ a3);
          t[c+3] = a3 ^ al ^ xt(a3 ^ a0);
        end
      end
      k = key_fwd(in_slot.key, in_slot.rc);
    end else begin
      if (!first) begin
        // inverse mix via the standard pre-step on top of forward mix
        for (int c = 0; c < 16; c += 4) begin
          u = xt(xt(s[c] ^ s[c+2]));
          v = xt(xt(s[c+1] ^ s[c+3]));
          s[c] = s[c] ^ u; s[c+1] = s[c+1] ^ v;
          s[c+2] = s[c+2] ^ u; s[c+3] = s[c+3] ^ v;
          a0 = s[c]; a1 = s[c+1]; a2 = s[c+2]; a3 = s[c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          s[c]   = a0 ^ al ^ xt(a0 ^ a1);
          s[c+1] = a1 ^ al ^ xt(a1 ^ a2);
          s[c+2] = a2 ^ al ^ xt(a2 ^ a3);
          s[c+3] = a3 ^ al ^ xt(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = INV_SBOX[s[i]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r+4*c] = s[r + 4*((c+4-r) & 3)];
      k = key_bwd(in_slot.key, in_slot.rc);
    end
    for (int i = 0; i < 16; i++) nx.st[127-8*i -: 8] = t[i] ^ get_byte(k, i);
    nx.key = k;
    nx.rc  = rc_next(in_slot.dec, in_slot.rc);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_slot <= nx;
    end
  end

endmodule
`default_nettype wire

>>> design/aes128_block_cipher_core.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher_core
// pipelined aes-128 encrypt / decrypt; if not stalled, one block per cycle
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: tdata = {block_low, block_high} (block_high in
//   bits 63:0), tuser = func (0 encrypt, 1 decrypt).
//   m_axis returns the result block: tdata bits 63:0 out_high, 127:64 out_low.
//   cfg writes the key registers: index 0/1 cipher key high/low, 2/3 final
//   round key high/low used to start decryption; other indexes are ignored.
// Pipeline: twelve register stages: key-add stage loaded at acceptance,
//   ten round stages, one output register, which drives m_axis_tvalid.
// Throughput: one item per cycle when not stalled; each round stage is a
//   full registered round unit, so blocks of either kind interleave freely.
// Reset clears all valid bits and the key registers to zero.
// A stall at m_axis freezes the whole pipeline; s_axis_tready falls with it,
//   and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_block_cipher_core
  import aes_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [127:0]         s_axis_tdata,  // block_low, block_high
  input  wire logic                 s_axis_tuser,  // func
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [127:0]              m_axis_tdata,  // out_low, out_high
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic [63:0] enc_key_high, enc_key_low, dec_key_high, dec_key_low;
  logic        en;
  logic        v [NumRounds+1];
  slot_t       sl [NumRounds+1];

  assign cfg_ready     = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_key_high <= '0;
      enc_key_low  <= '0;
      dec_key_high <= '0;
      dec_key_low  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENC_KEY_HIGH: enc_key_high <= cfg_data;
        REG_ENC_KEY_LOW:  enc_key_low  <= cfg_data;
        REG_DEC_KEY_HIGH: dec_key_high <= cfg_data;
        REG_DEC_KEY_LOW:  dec_key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // initial key addition stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl[0].dec <= s_axis_tuser;
      if (s_axis_tuser == FUNC_DEC) begin
        sl[0].key <= {dec_key_high, dec_key_low};
        sl[0].st  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^
                     {dec_key_high, dec_key_low};
        sl[0].rc  <= RconDecStart;
      end else begin
        sl[0].key <= {enc_key_high, enc_key_low};
        sl[0].st  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^
                     {enc_key_high, enc_key_low};
        sl[0].rc  <= RconEncStart;
      end
    end
  end

  // ten round stages
  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    aes_round u_rnd (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v[g]),
      .in_slot   (sl[g]),
      .first     (g == 0),
      .last      (g == NumRounds-1),
      .out_valid (v[g+1]),
      .out_slot  (sl[g+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {sl[NumRounds].st[63:0], sl[NumRounds].st[127:64]};
    end
  end

endmodule
`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the aes-128 core: a short directed table with
// known vectors, then random blocks over several key settings, each result
// checked against a behavioural cipher model held here
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
  import aes_pkg::*;

  typedef struct {
    logic        func;
    logic [63:0] in_hi;
    logic [63:0] in_lo;
    logic        known;
    logic [63:0] res_hi;
    logic [63:0] res_lo;
  } vec_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_pair_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  // key registers as the block should hold them
  logic [63:0] ek_hi, ek_lo, dk_hi, dk_lo;
  logic [7:0]  inv_sub [256];
  blk_pair_t   pending_blocks [$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b1;

  aes128_block_cipher_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gf(2^8) arithmetic
  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input int m);
    logic [7:0] acc;
    acc = 8'h00;
    while (m != 0) begin
      if (m & 1) acc ^= a;
      a = gf_dbl(a);
      m = m >> 1;
    end
    return acc;
  endfunction

  // round key schedule, forward and backward by one round
  function automatic logic [127:0] round_key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [7:0] b [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = k[127-8*i -: 8];
    b[0] ^= SBOX[b[13]] ^ rc;
    b[1] ^= SBOX[b[14]];
    b[2] ^= SBOX[b[15]];
    b[3] ^= SBOX[b[12]];
    for (int i = 4; i < 16; i++) b[i] ^= b[i-4];
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
    return r;
  endfunction

  function automatic logic [127:0] round_key_prev(input logic [127:0] k, input logic [7:0] rc);
    logic [7:0] b [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = k[127-8*i -: 8];
    for (int i = 15; i >= 4; i--) b[i] ^= b[i-4];
    b[0] ^= SBOX[b[13]] ^ rc;
    b[1] ^= SBOX[b[14]];
    b[2] ^= SBOX[b[15]];
    b[3] ^= SBOX[b[12]];
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
    return r;
  endfunction

  // tenth round key of a cipher key
  function automatic logic [127:0] last_round_key(input logic [127:0] k);
    logic [7:0] rc;
    rc = 8'h01;
    for (int n = 0; n < 10; n++) begin
      k = round_key_next(k, rc);
      rc = gf_dbl(rc);
    end
    return k;
  endfunction

  // full block transform under the current key registers
  function automatic blk_pair_t cipher_block(input logic func, input logic [63:0] hi,
                                             input logic [63:0] lo);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] k, blk;
    logic [7:0] rc;
    blk_pair_t res;
    blk = {hi, lo};
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    k = (func == FUNC_DEC) ? {dk_hi, dk_lo} : {ek_hi, ek_lo};
    rc = (func == FUNC_DEC) ? RconDecStart : RconEncStart;
    for (int i = 0; i < 16; i++) s[i] ^= k[127-8*i -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      if (func == FUNC_ENC) begin
        for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[r+4*c] = s[r+4*((c+r)%4)];
        s = t;
        if (rnd != 10) begin
          for (int c = 0; c < 16; c += 4) begin
            a0 = s[c]; a1 = s[c+1]; a2 = s[c+2]; a3 = s[c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            s[c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
            s[c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
            s[c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
            s[c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
          end
        end
        k = round_key_next(k, rc);
        rc = gf_dbl(rc);
      end else begin
        if (rnd != 1) begin
          for (int c = 0; c < 16; c += 4) begin
            a0 = s[c]; a1 = s[c+1]; a2 = s[c+2]; a3 = s[c+3];
            s[c]   = gf_mul(a0,14) ^ gf_mul(a1,11) ^ gf_mul(a2,13) ^ gf_mul(a3,9);
            s[c+1] = gf_mul(a0,9) ^ gf_mul(a1,14) ^ gf_mul(a2,11) ^ gf_mul(a3,13);
            s[c+2] = gf_mul(a0,13) ^ gf_mul(a1,9) ^ gf_mul(a2,14) ^ gf_mul(a3,11);
            s[c+3] = gf_mul(a0,11) ^ gf_mul(a1,13) ^ gf_mul(a2,9) ^ gf_mul(a3,14);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = inv_sub[s[i]];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[r+4*c] = s[r+4*((c+4-r)%4)];
        s = t;
        k = round_key_prev(k, rc);
        rc = rc[0] ? RconDecWrap : {1'b0, rc[7:1]};
      end
      for (int i = 0; i < 16; i++) s[i] ^= k[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
    res.hi = blk[127:64];
    res.lo = blk[63:0];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_key_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENC_KEY_HIGH: ek_hi = val;
      REG_ENC_KEY_LOW:  ek_lo = val;
      REG_DEC_KEY_HIGH: dk_hi = val;
      REG_DEC_KEY_LOW:  dk_lo = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_keys(input logic [63:0] eh, input logic [63:0] el,
                           input bit matched, input logic [63:0] dh, input logic [63:0] dl);
    logic [127:0] lk;
    lk = last_round_key({eh, el});
    write_key_reg(REG_ENC_KEY_HIGH, eh);
    write_key_reg(REG_ENC_KEY_LOW, el);
    write_key_reg(REG_DEC_KEY_HIGH, matched ? lk[127:64] : dh);
    write_key_reg(REG_DEC_KEY_LOW, matched ? lk[63:0] : dl);
  endtask

  // offer one item, with an optional gap in front, and queue its result
  task automatic send_block(input vec_t v);
    blk_pair_t exp_blk;
    int gap;
    gap = 0;
    if (gaps_on) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(8, 40);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= v.func;
    s_axis_tdata  <= {v.in_lo, v.in_hi};
    do @(posedge clk); while (!s_axis_tready);
    exp_blk = cipher_block(v.func, v.in_hi, v.in_lo);
    if (v.known && (exp_blk.hi !== v.res_hi || exp_blk.lo !== v.res_lo)) begin
      $error("known vector out_high exp %h got %h, out_low exp %h got %h (model)",
             v.res_hi, exp_blk.hi, v.res_lo, exp_blk.lo);
      fail_count++;
    end
    if (v.known) begin
      exp_blk.hi = v.res_hi;
      exp_blk.lo = v.res_lo;
    end
    pending_blocks.push_back(exp_blk);
    items_sent++;
  endtask

  // drop valid and let the pipeline empty
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_blocks.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    blk_pair_t exp_blk;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_blocks.size() == 0) begin
        $error("result item with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_blk = pending_blocks.pop_front();
        if (m_axis_tdata[63:0] !== exp_blk.hi) begin
          $error("out_high exp %h got %h", exp_blk.hi, m_axis_tdata[63:0]);
          fail_count++;
        end
        if (m_axis_tdata[127:64] !== exp_blk.lo) begin
          $error("out_low exp %h got %h", exp_blk.lo, m_axis_tdata[127:64]);
          fail_count++;
        end
      end
    end
  end

  // receiver back-pressure, with one long hold-off while items keep coming
  initial begin
    bit held;
    int n;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && items_sent > 400) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (120) @(negedge clk);
      end else if (!gaps_on || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end else begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    vec_t rst_rows [4];
    vec_t fips_rows [10];
    vec_t v;
    int cnt;
    for (int i = 0; i < 256; i++) inv_sub[SBOX[i]] = i[7:0];
    ek_hi = '0; ek_lo = '0; dk_hi = '0; dk_lo = '0;

    // all-zero keys straight after reset
    rst_rows = '{
      '{FUNC_ENC, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{FUNC_ENC, '1, '1, 1'b0, '0, '0},
      '{FUNC_DEC, 64'h0, 64'h0, 1'b0, '0, '0},
      '{FUNC_DEC, '1, '1, 1'b0, '0, '0}
    };
    // standard example key and its tenth round key
    fips_rows = '{
      '{FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
        64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{FUNC_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
        64'h0011223344556677, 64'h8899aabbccddeeff},
      '{FUNC_ENC, '0, '0, 1'b0, '0, '0},
      '{FUNC_ENC, '1, '1, 1'b0, '0, '0},
      '{FUNC_DEC, '0, '0, 1'b0, '0, '0},
      '{FUNC_DEC, '1, '1, 1'b0, '0, '0},
      '{FUNC_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, '0, '0},
      '{FUNC_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, '0, '0},
      '{FUNC_ENC, 64'h8000000000000000, 64'h0000000000000001, 1'b0, '0, '0},
      '{FUNC_DEC, 64'h0000000000000001, 64'h8000000000000000, 1'b0, '0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rst_rows[i]) send_block(rst_rows[i]);
    drain();
    load_keys(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1, '0, '0);
    foreach (fips_rows[i]) send_block(fips_rows[i]);
    drain();

    // random phases; decryption key matched, unrelated and at the extremes
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        2: load_keys('1, '1, 1'b0, '1, '1);
        4: load_keys('0, '0, 1'b0, '1, '0);
        5: load_keys({$urandom, $urandom}, {$urandom, $urandom}, 1'b0,
                     {$urandom, $urandom}, {$urandom, $urandom});
        default: load_keys({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, '0, '0);
      endcase
      gaps_on = (ph != 3);
      cnt = 200;
      for (int n = 0; n < cnt; n++) begin
        v.func  = $urandom_range(0, 1);
        v.in_hi = rand64();
        v.in_lo = rand64();
        v.known = 1'b0;
        v.res_hi = '0;
        v.res_lo = '0;
        send_block(v);
        // round trip: decrypt what was just encrypted
        if (v.func == FUNC_ENC && $urandom_range(0, 3) == 0) begin
          v.func = FUNC_DEC;
          {v.in_hi, v.in_lo} = {cipher_block(FUNC_ENC, v.in_hi, v.in_lo).hi,
                                cipher_block(FUNC_ENC, v.in_hi, v.in_lo).lo};
          send_block(v);
        end
      end
      // sender waits for every result before carrying on
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_blocks.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
